// ===== hw/rtl/bnfa_pkg.sv =====
// Package for the next-fit bitmap slot allocator.
// Sizes, command and status codes, state encoding, control structs, bit search.
// Used by bnfa_ctrl, bnfa_dp and bitmap_next_fit_slot_allocator_top.
package bnfa_pkg;

    // Store geometry; SLOTS is a power of two, at least two used-map rows
    localparam int SLOTS      = 1024;
    localparam int DATA_WIDTH = 64;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int MAP_W      = 64;
    localparam int ROWS       = SLOTS / MAP_W;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int BIT_W      = $clog2(MAP_W);
    localparam int STEP_W     = ROW_W + 1;

    // Fixed port widths
    localparam int CMD_W      = 3;
    localparam int IDX_W      = 11;
    localparam int OSLOT_W    = 10;
    localparam int XDATA_W    = 64;
    localparam int ST_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC_ZERO = 3'd0,
        CMD_ALLOC_DATA = 3'd1,
        CMD_FREE       = 3'd2,
        CMD_READ       = 3'd3,
        CMD_WRITE      = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_UNALLOC = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEC,
        S_CHK,
        S_SCAN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic cap;   // capture a new transaction
        logic imm;   // answer without touching the store
        logic acc;   // finish free, read or write
        logic scan;  // one step of the allocation scan
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_alloc;
        logic acc_ok;
        logic scan_end;
    } t_dp_sts;

    // Index of the lowest set bit; zero when none is set
    function automatic logic [BIT_W-1:0] first_set(input logic [MAP_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bitmap_next_fit_slot_allocator_top.sv =====
// Top level of the next-fit bitmap slot allocator.
// A range error or unknown command is answered from decode; free/read/write go through
// an access check; allocate scans the used map, one 64-bit used-map row per cycle.
// Busy stays high until the result strobe; the next command is taken in that cycle.
// Reset: synchronous, clears the used map at once through row valid bits and the
// rover; the slot data store is not cleared. Results cannot be held off.
module bitmap_next_fit_slot_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bnfa_pkg::CMD_W-1:0]    i_cmd,
    input  logic [bnfa_pkg::IDX_W-1:0]    i_slot_in,
    input  logic [bnfa_pkg::XDATA_W-1:0]  i_data_in,
    output logic                          o_done,
    output logic [bnfa_pkg::ST_W-1:0]     o_status,
    output logic [bnfa_pkg::OSLOT_W-1:0]  o_slot_out,
    output logic [bnfa_pkg::XDATA_W-1:0]  o_data_out
);

    bnfa_pkg::t_dp_cmd dp_cmd;
    bnfa_pkg::t_dp_sts dp_sts;

    // Controller
    bnfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    // Datapath
    bnfa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_cmd_in   (i_cmd),
        .i_slot_in  (i_slot_in),
        .i_data_in  (i_data_in),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_slot_out (o_slot_out),
        .o_data_out (o_data_out)
    );

    // An accepted command makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    // A full store grants no slot
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == bnfa_pkg::ST_FULL)) |-> (o_slot_out == '0))
        else $error("full status with nonzero slot");

    // Data is returned only with ok status
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_data_out != '0)) |-> (o_status == bnfa_pkg::ST_OK))
        else $error("data returned with error status");

endmodule

// ===== hw/rtl/bnfa_ctrl.sv =====
// Controller state machine of the slot allocator.
// Sequences decode, access check and the used-map scan. Depends on bnfa_pkg.
module bnfa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bnfa_pkg::t_dp_sts  i_sts,
    output bnfa_pkg::t_dp_cmd  o_cmd
);

    bnfa_pkg::t_state r_state;
    bnfa_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bnfa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bnfa_pkg::S_IDLE: begin
                if (start) begin
                    n_state = bnfa_pkg::S_DEC;
                end
            end
            bnfa_pkg::S_DEC: begin
                priority if (i_sts.is_alloc) begin
                    n_state = bnfa_pkg::S_SCAN;
                end else if (i_sts.acc_ok) begin
                    n_state = bnfa_pkg::S_CHK;
                end else begin
                    n_state = bnfa_pkg::S_IDLE;
                end
            end
            bnfa_pkg::S_CHK: begin
                n_state = bnfa_pkg::S_IDLE;
            end
            bnfa_pkg::S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = bnfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bnfa_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            bnfa_pkg::S_IDLE: begin
                busy      = 1'b0;
                o_cmd.cap = start;
            end
            bnfa_pkg::S_DEC: begin
                o_cmd.imm = !i_sts.is_alloc && !i_sts.acc_ok;
            end
            bnfa_pkg::S_CHK: begin
                o_cmd.acc = 1'b1;
            end
            bnfa_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bnfa_dp.sv =====
// Datapath of the slot allocator: used map, slot data store, rover, result.
// Scans one used-map row per cycle. Depends on bnfa_pkg.
module bnfa_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bnfa_pkg::t_dp_cmd                  i_cmd,
    output bnfa_pkg::t_dp_sts                  o_sts,
    input  logic [bnfa_pkg::CMD_W-1:0]         i_cmd_in,
    input  logic [bnfa_pkg::IDX_W-1:0]         i_slot_in,
    input  logic [bnfa_pkg::XDATA_W-1:0]       i_data_in,
    output logic                               o_done,
    output logic [bnfa_pkg::ST_W-1:0]          o_status,
    output logic [bnfa_pkg::OSLOT_W-1:0]       o_slot_out,
    output logic [bnfa_pkg::XDATA_W-1:0]       o_data_out
);

    // Captured transaction
    logic [bnfa_pkg::CMD_W-1:0]       r_cmd;
    logic [bnfa_pkg::IDX_W-1:0]       r_slot;
    logic [bnfa_pkg::DATA_WIDTH-1:0]  r_data;

    // Store state
    logic [bnfa_pkg::MAP_W-1:0]       map_mem [bnfa_pkg::ROWS];
    logic [bnfa_pkg::DATA_WIDTH-1:0]  dat_mem [bnfa_pkg::SLOTS];
    logic [bnfa_pkg::ROWS-1:0]        r_row_vld;
    logic [bnfa_pkg::SLOT_W-1:0]      r_rover;

    // Registered reads
    logic [bnfa_pkg::MAP_W-1:0]       r_map_q;
    logic                             r_vld_q;
    logic [bnfa_pkg::DATA_WIDTH-1:0]  r_dat_q;

    // Scan bookkeeping
    logic [bnfa_pkg::STEP_W-1:0]      r_iss;
    logic [bnfa_pkg::STEP_W-1:0]      r_chk;
    logic                             r_chk_vld;

    // Result
    logic                             r_done;
    logic [bnfa_pkg::ST_W-1:0]        r_status;
    logic [bnfa_pkg::OSLOT_W-1:0]     r_slot_out;
    logic [bnfa_pkg::XDATA_W-1:0]     r_data_out;

    logic                             in_rng;
    logic                             is_access;
    logic                             is_alloc;
    logic [bnfa_pkg::SLOT_W-1:0]      s_idx;
    logic [bnfa_pkg::ROW_W-1:0]       s_row;
    logic [bnfa_pkg::BIT_W-1:0]       s_bit;
    logic [bnfa_pkg::ROW_W-1:0]       w0;
    logic [bnfa_pkg::BIT_W-1:0]       lo;
    logic [bnfa_pkg::ROW_W-1:0]       chk_row;
    logic [bnfa_pkg::ROW_W-1:0]       rd_row;
    logic [bnfa_pkg::MAP_W-1:0]       map_word;
    logic [bnfa_pkg::MAP_W-1:0]       chk_mask;
    logic [bnfa_pkg::MAP_W-1:0]       free_bits;
    logic [bnfa_pkg::BIT_W-1:0]       fbit;
    logic                             hit;
    logic                             last_step;
    logic                             scan_end;
    logic                             used_bit;
    logic [bnfa_pkg::SLOT_W-1:0]      grant;

    logic                             map_we;
    logic [bnfa_pkg::ROW_W-1:0]       map_wrow;
    logic [bnfa_pkg::MAP_W-1:0]       map_wdata;
    logic                             dat_we;
    logic [bnfa_pkg::SLOT_W-1:0]      dat_waddr;
    logic [bnfa_pkg::DATA_WIDTH-1:0]  dat_wdata;

    // Decode of the captured command
    assign in_rng    = 32'(r_slot) < 32'(bnfa_pkg::SLOTS);
    assign is_alloc  = (r_cmd == bnfa_pkg::CMD_ALLOC_ZERO) ||
                       (r_cmd == bnfa_pkg::CMD_ALLOC_DATA);
    assign is_access = (r_cmd == bnfa_pkg::CMD_FREE) ||
                       (r_cmd == bnfa_pkg::CMD_READ) ||
                       (r_cmd == bnfa_pkg::CMD_WRITE);
    assign s_idx     = r_slot[bnfa_pkg::SLOT_W-1:0];
    assign s_row     = s_idx[bnfa_pkg::SLOT_W-1:bnfa_pkg::BIT_W];
    assign s_bit     = s_idx[bnfa_pkg::BIT_W-1:0];

    // Scan addressing: step k looks at row (rover row + k), wrapping
    assign w0       = r_rover[bnfa_pkg::SLOT_W-1:bnfa_pkg::BIT_W];
    assign lo       = r_rover[bnfa_pkg::BIT_W-1:0];
    assign chk_row  = w0 + r_chk[bnfa_pkg::ROW_W-1:0];
    assign rd_row   = i_cmd.scan ? (w0 + r_iss[bnfa_pkg::ROW_W-1:0]) : s_row;
    assign map_word = r_vld_q ? r_map_q : '0;

    // First step: bits at or above the rover; last step: bits below it
    assign last_step = (r_chk == bnfa_pkg::STEP_W'(bnfa_pkg::ROWS));
    always_comb begin
        priority if (r_chk == '0) begin
            chk_mask = {bnfa_pkg::MAP_W{1'b1}} << lo;
        end else if (last_step) begin
            chk_mask = ~({bnfa_pkg::MAP_W{1'b1}} << lo);
        end else begin
            chk_mask = {bnfa_pkg::MAP_W{1'b1}};
        end
    end

    assign free_bits = ~map_word & chk_mask;
    assign fbit      = bnfa_pkg::first_set(free_bits);
    assign hit       = r_chk_vld && (|free_bits);
    assign scan_end  = r_chk_vld && (hit || last_step);
    assign grant     = {chk_row, fbit};
    assign used_bit  = map_word[s_bit];

    assign o_sts.is_alloc = is_alloc;
    assign o_sts.acc_ok   = is_access && in_rng;
    assign o_sts.scan_end = scan_end;

    // Store write selection
    always_comb begin
        map_we    = 1'b0;
        map_wrow  = s_row;
        map_wdata = map_word & ~(bnfa_pkg::MAP_W'(1) << s_bit);
        dat_we    = 1'b0;
        dat_waddr = s_idx;
        dat_wdata = r_data;
        if (i_cmd.scan && hit) begin
            map_we    = 1'b1;
            map_wrow  = chk_row;
            map_wdata = map_word | (bnfa_pkg::MAP_W'(1) << fbit);
            dat_we    = 1'b1;
            dat_waddr = grant;
            dat_wdata = (r_cmd == bnfa_pkg::CMD_ALLOC_DATA) ? r_data : '0;
        end else if (i_cmd.acc && used_bit) begin
            map_we = (r_cmd == bnfa_pkg::CMD_FREE);
            dat_we = (r_cmd == bnfa_pkg::CMD_WRITE);
        end
    end

    // Used-map memory and its registered read
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_wrow] <= map_wdata;
        end
        r_map_q <= map_mem[rd_row];
        r_vld_q <= r_row_vld[rd_row];
    end

    // Slot data memory and its registered read
    always_ff @(posedge i_clk) begin
        if (dat_we) begin
            dat_mem[dat_waddr] <= dat_wdata;
        end
        r_dat_q <= dat_mem[s_idx];
    end

    // Row valid bits: a row not yet written reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (map_we) begin
            r_row_vld[map_wrow] <= 1'b1;
        end
    end

    // Transaction capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_cmd  <= i_cmd_in;
            r_slot <= i_slot_in;
            r_data <= i_data_in[bnfa_pkg::DATA_WIDTH-1:0];
        end
    end

    // Scan counters and rover
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss     <= '0;
            r_chk     <= '0;
            r_chk_vld <= 1'b0;
            r_rover   <= '0;
        end else begin
            if (i_cmd.cap) begin
                r_iss     <= '0;
                r_chk_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_iss     <= r_iss + 1'b1;
                r_chk     <= r_iss;
                r_chk_vld <= 1'b1;
            end
            if (i_cmd.scan && hit) begin
                r_rover <= grant;
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.imm || i_cmd.acc || (i_cmd.scan && scan_end);
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.imm) begin
            r_status   <= is_access ? bnfa_pkg::ST_RANGE : bnfa_pkg::ST_OK;
            r_slot_out <= r_slot[bnfa_pkg::OSLOT_W-1:0];
            r_data_out <= '0;
        end else if (i_cmd.acc) begin
            r_status   <= used_bit ? bnfa_pkg::ST_OK : bnfa_pkg::ST_UNALLOC;
            r_slot_out <= r_slot[bnfa_pkg::OSLOT_W-1:0];
            r_data_out <= (used_bit && (r_cmd == bnfa_pkg::CMD_READ)) ?
                          bnfa_pkg::XDATA_W'(r_dat_q) : '0;
        end else if (i_cmd.scan && scan_end) begin
            r_status   <= hit ? bnfa_pkg::ST_OK : bnfa_pkg::ST_FULL;
            r_slot_out <= hit ? bnfa_pkg::OSLOT_W'(grant) : '0;
            r_data_out <= '0;
        end
    end

    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_slot_out = r_slot_out;
    assign o_data_out = r_data_out;

endmodule
